[rtl/pfd_pkg.sv]
// shared types, constants and helpers of the point frame deframer
// no dependencies

package pfd_pkg;

	// result kinds
	localparam logic [2:0] KIND_POINT_REQ = 3'd0;
	localparam logic [2:0] KIND_POINT_CMD = 3'd1;
	localparam logic [2:0] KIND_TIME_REQ  = 3'd2;
	localparam logic [2:0] KIND_TIME_SET  = 3'd3;
	localparam logic [2:0] KIND_BAD_TYPE  = 3'd4;
	localparam logic [2:0] KIND_BAD_TAIL  = 3'd5;

	// frame bytes
	localparam logic [31:0] HEAD_PREFIX  = 32'h7B48_4541; // "{HEA"
	localparam logic [7:0]  HEAD_LAST    = 8'h44;         // "D"
	localparam logic [7:0]  TIME_MARK    = 8'h0F;
	localparam logic [7:0]  TYPE_REQUEST = 8'h00;
	localparam logic [7:0]  TYPE_SET     = 8'h40;

	// byte positions counted from the first header byte
	localparam logic [4:0] POS_AFTER_HEAD = 5'd5;
	localparam logic [4:0] POS_MARK       = 5'd5;
	localparam logic [4:0] POS_TYPE       = 5'd8;
	localparam logic [4:0] POS_GROUP      = 5'd12;
	localparam logic [4:0] POS_INDEX      = 5'd13;
	localparam logic [4:0] POS_VALUE_LO   = 5'd14;
	localparam logic [4:0] POS_VALUE_HI   = 5'd17;
	localparam logic [4:0] POS_DATE_LO    = 5'd12;
	localparam logic [4:0] POS_DATE_HI    = 5'd16;
	localparam logic [4:0] POS_TAIL_REQ   = 5'd16;
	localparam logic [4:0] POS_TAIL_STD   = 5'd20;
	localparam logic [4:0] TAIL_LEN_M1    = 5'd4;

	localparam int QUEUE_DEPTH_DEF = 4;

	// one-hot parser modes
	typedef enum logic [6:0] {
		MODE_HUNT       = 7'b000_0001,
		MODE_POINT_HDR  = 7'b000_0010,
		MODE_TIME_HDR   = 7'b000_0100,
		MODE_TIME_PLAIN = 7'b000_1000,
		MODE_TIME_SET   = 7'b001_0000,
		MODE_REQ        = 7'b010_0000,
		MODE_CMD        = 7'b100_0000
	} pfd_mode_t;

	// one decoded result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  point_group;
		logic [7:0]  point_index;
		logic [31:0] point_value;
		logic [7:0]  year_offset;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
	} pfd_result_t;

	// expected tail text "TAIL}"
	function automatic logic [7:0] tail_byte(input logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0: r = 8'h54;
			3'd1: r = 8'h41;
			3'd2: r = 8'h49;
			3'd3: r = 8'h4C;
			3'd4: r = 8'h7D;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[rtl/pfd_if.sv]
// valid/ready channel interfaces of the point frame deframer
// depends on nothing but the clock domain of the user

interface pfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       chunk_end;

	modport source (output valid, output rx_byte, output chunk_end, input ready);
	modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface pfd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  point_group;
	logic [7:0]  point_index;
	logic [31:0] point_value;
	logic [7:0]  year_offset;
	logic [7:0]  month;
	logic [7:0]  day;
	logic [7:0]  hour;
	logic [7:0]  minute;

	modport source (output valid, output kind, output point_group, output point_index,
		output point_value, output year_offset, output month, output day,
		output hour, output minute, input ready);
	modport sink (input valid, input kind, input point_group, input point_index,
		input point_value, input year_offset, input month, input day,
		input hour, input minute, output ready);
endinterface

[rtl/pfd_parser.sv]
// front part: header hunt, frame classification and field capture
// depends on pfd_pkg

module pfd_parser import pfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  rx_byte,
	input  logic        chunk_end,
	output logic        res_valid,
	output pfd_result_t res
);

	logic [31:0] window_q, window_d;
	logic [4:0]  pos_q, pos_d;
	pfd_mode_t   mode_q, mode_d;
	logic        discard_q, discard_d;
	logic        tail_ok_q, tail_ok_d;
	logic [7:0]  group_q, group_d;
	logic [7:0]  index_q, index_d;
	logic [31:0] value_q, value_d;
	logic [7:0]  date_q [5];
	logic [7:0]  date_d [5];

	logic [4:0]  tail_start;
	logic [4:0]  tail_rel;
	logic        bad_type;

	// next state and result for the byte at the input
	always_comb begin
		window_d  = window_q;
		pos_d     = pos_q;
		mode_d    = mode_q;
		discard_d = discard_q;
		tail_ok_d = tail_ok_q;
		group_d   = group_q;
		index_d   = index_q;
		value_d   = value_q;
		date_d    = date_q;
		bad_type  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		tail_start = POS_TAIL_STD;
		tail_rel   = '0;
		if (discard_q) begin
			// drop bytes up to the end of the chunk
			if (chunk_end) begin
				discard_d = 1'b0;
			end
		end else if (mode_q == MODE_HUNT) begin
			if (window_q == HEAD_PREFIX && rx_byte == HEAD_LAST) begin
				window_d  = '0;
				mode_d    = MODE_POINT_HDR;
				pos_d     = POS_AFTER_HEAD;
				tail_ok_d = 1'b1;
			end else begin
				window_d = {window_q[23:0], rx_byte};
			end
		end else begin
			// classify on the marker and type bytes
			if (pos_q == POS_MARK && rx_byte == TIME_MARK) begin
				mode_d = MODE_TIME_HDR;
			end
			if (pos_q == POS_TYPE) begin
				if (mode_d == MODE_TIME_HDR) begin
					if (rx_byte == TYPE_REQUEST) begin
						mode_d    = MODE_TIME_PLAIN;
						res_valid = 1'b1;
						res.kind  = KIND_TIME_REQ;
					end else if (rx_byte == TYPE_SET) begin
						mode_d = MODE_TIME_SET;
					end else begin
						mode_d = MODE_TIME_PLAIN;
					end
				end else if (rx_byte == TYPE_REQUEST) begin
					mode_d = MODE_REQ;
				end else if (rx_byte == TYPE_SET) begin
					mode_d = MODE_CMD;
				end else begin
					bad_type = 1'b1;
				end
			end

			if (bad_type) begin
				res_valid = 1'b1;
				res.kind  = KIND_BAD_TYPE;
				mode_d    = MODE_HUNT;
				pos_d     = '0;
				window_d  = '0;
				tail_ok_d = 1'b1;
				discard_d = !chunk_end;
			end else begin
				// point fields
				if (mode_d == MODE_REQ || mode_d == MODE_CMD) begin
					if (pos_q == POS_GROUP) begin
						group_d = rx_byte;
					end
					if (pos_q == POS_INDEX) begin
						index_d = rx_byte;
						if (mode_d == MODE_REQ) begin
							res_valid       = 1'b1;
							res.kind        = KIND_POINT_REQ;
							res.point_group = group_q;
							res.point_index = rx_byte;
						end
					end
					if (mode_d == MODE_CMD && pos_q >= POS_VALUE_LO
							&& pos_q <= POS_VALUE_HI) begin
						value_d = {value_q[23:0], rx_byte};
						if (pos_q == POS_VALUE_HI) begin
							res_valid       = 1'b1;
							res.kind        = KIND_POINT_CMD;
							res.point_group = group_q;
							res.point_index = index_q;
							res.point_value = {value_q[23:0], rx_byte};
						end
					end
				end

				// date fields of a time set
				if (mode_d == MODE_TIME_SET && pos_q >= POS_DATE_LO
						&& pos_q <= POS_DATE_HI) begin
					date_d[3'(pos_q - POS_DATE_LO)] = rx_byte;
					if (pos_q == POS_DATE_HI) begin
						res_valid       = 1'b1;
						res.kind        = KIND_TIME_SET;
						res.year_offset = date_q[0];
						res.month       = date_q[1];
						res.day         = date_q[2];
						res.hour        = date_q[3];
						res.minute      = rx_byte;
					end
				end

				// tail check and frame end
				tail_start = (mode_d == MODE_REQ) ? POS_TAIL_REQ : POS_TAIL_STD;
				tail_rel   = pos_q - tail_start;
				pos_d      = pos_q + 5'd1;
				if (pos_q >= tail_start && tail_rel <= TAIL_LEN_M1) begin
					tail_ok_d = tail_ok_q && (rx_byte == tail_byte(tail_rel[2:0]));
					if (tail_rel == TAIL_LEN_M1) begin
						if (!tail_ok_d) begin
							res_valid = 1'b1;
							res       = '0;
							res.kind  = KIND_BAD_TAIL;
							discard_d = !chunk_end;
						end
						mode_d    = MODE_HUNT;
						pos_d     = '0;
						window_d  = '0;
						tail_ok_d = 1'b1;
					end
				end
			end
		end
		if (!fire) begin
			res_valid = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			pos_q     <= '0;
			mode_q    <= MODE_HUNT;
			discard_q <= 1'b0;
			tail_ok_q <= 1'b1;
		end else if (fire) begin
			window_q  <= window_d;
			pos_q     <= pos_d;
			mode_q    <= mode_d;
			discard_q <= discard_d;
			tail_ok_q <= tail_ok_d;
		end
	end

	// captured fields
	always_ff @(posedge clk) begin
		if (fire) begin
			group_q <= group_d;
			index_q <= index_d;
			value_q <= value_d;
			date_q  <= date_d;
		end
	end

endmodule

[rtl/pfd_queue.sv]
// result queue between parser and output side, also the output register
// depends on pfd_pkg

module pfd_queue import pfd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pfd_result_t push_data,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output pfd_result_t head
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	pfd_result_t     entry_q [DEPTH];
	logic [IW-1:0]   wr_q;
	logic [IW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_q];
	assign do_pop     = pop && head_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + IW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + IW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

[rtl/point_frame_deframer_unit.sv]
// Point frame deframer: takes one received byte per cycle, hunts for the
// "{HEAD" header and decodes point request, point command, time request and
// time set frames, flagging bad type bytes of point frames and bad tails. A
// byte is taken in every cycle in which the result queue (QUEUE_DEPTH items)
// has room; with the output side ready the queue never fills and the block
// sustains one byte per clock. A result is registered in the queue when the
// byte completing it is accepted, and is offered on out_ch until taken.
// depends on pfd_pkg, pfd_if, pfd_parser, pfd_queue

module point_frame_deframer_unit import pfd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pfd_in_if.sink    in_ch,
	pfd_out_if.source out_ch
);

	logic        fire;
	logic        res_valid;
	pfd_result_t res;
	logic        full;
	pfd_result_t head;

	assign in_ch.ready = !full;
	assign fire        = in_ch.valid && !full;

	// front: parse bytes
	pfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.rx_byte   (in_ch.rx_byte),
		.chunk_end (in_ch.chunk_end),
		.res_valid (res_valid),
		.res       (res)
	);

	// back: queue and deliver results
	pfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.full       (full),
		.pop        (out_ch.ready),
		.head_valid (out_ch.valid),
		.head       (head)
	);

	assign out_ch.kind        = head.kind;
	assign out_ch.point_group = head.point_group;
	assign out_ch.point_index = head.point_index;
	assign out_ch.point_value = head.point_value;
	assign out_ch.year_offset = head.year_offset;
	assign out_ch.month       = head.month;
	assign out_ch.day         = head.day;
	assign out_ch.hour        = head.hour;
	assign out_ch.minute      = head.minute;

endmodule

[rtl/pfd_checker.sv]
// port-level checks of the point frame deframer, bound to the top level
// depends on pfd_pkg and point_frame_deframer_unit

module pfd_checker import pfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [7:0]  point_group,
	input logic [7:0]  point_index,
	input logic [31:0] point_value,
	input logic [7:0]  year_offset,
	input logic [7:0]  month,
	input logic [7:0]  day,
	input logic [7:0]  hour,
	input logic [7:0]  minute
);

	// a waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// only defined kinds leave the block
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= KIND_BAD_TAIL)
		else $error("undefined result kind");

	// point fields only on point results, value only on commands
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_POINT_REQ && kind != KIND_POINT_CMD
		|-> point_group == 8'd0 && point_index == 8'd0)
		else $error("point fields set on non-point result");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_POINT_CMD |-> point_value == 32'd0)
		else $error("value set on non-command result");

	// date fields only on time set
	a_date_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_TIME_SET
		|-> (year_offset | month | day | hour | minute) == 8'd0)
		else $error("date fields set on non-time-set result");

endmodule

bind point_frame_deframer_unit pfd_checker u_pfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.kind        (out_ch.kind),
	.point_group (out_ch.point_group),
	.point_index (out_ch.point_index),
	.point_value (out_ch.point_value),
	.year_offset (out_ch.year_offset),
	.month       (out_ch.month),
	.day         (out_ch.day),
	.hour        (out_ch.hour),
	.minute      (out_ch.minute)
);

[verif/point_frame_deframer_unit_tb.sv]
// self-checking testbench of the point frame deframer: framed byte streams in, decoded items out
// predicts every decoded item on its own and checks each one as it leaves the block
// depends on pfd_pkg, pfd_if and point_frame_deframer_unit
`timescale 1ns / 100ps

module point_frame_deframer_unit_tb;
	import pfd_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BYTES  = 280;
	localparam int REPORT_MAX   = 10;
	localparam logic [39:0] TAIL_TEXT = 40'h54_41_49_4C_7D; // "TAIL}"

	// one byte of the link with its chunk end mark
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} link_byte_t;

	// tracks the deframer state and the decodes still owed by the block
	class point_frame_tracker;
		logic [31:0]  head_window;
		logic [4:0]   position;
		pfd_mode_t    mode;
		logic         dropping;
		logic [7:0]   group_b;
		logic [7:0]   index_b;
		logic [31:0]  value_acc;
		logic [7:0]   date_b [5];
		logic         tail_good;
		pfd_result_t  pending_decodes[$];
		int           decode_faults;
		int           bytes_taken;
		int           kind_seen [6];

		function new();
			head_window = '0;
			position    = '0;
			mode        = MODE_HUNT;
			dropping    = 1'b0;
			group_b     = '0;
			index_b     = '0;
			value_acc   = '0;
			foreach (date_b[k]) date_b[k] = '0;
			tail_good   = 1'b1;
			decode_faults = 0;
			bytes_taken = 0;
			foreach (kind_seen[k]) kind_seen[k] = 0;
		endfunction

		function void owe(input logic [2:0] kind, input logic point, input logic val,
			input logic dates);
			pfd_result_t r;
			r = '0;
			r.kind = kind;
			if (point) begin
				r.point_group = group_b;
				r.point_index = index_b;
			end
			if (val)
				r.point_value = value_acc;
			if (dates) begin
				r.year_offset = date_b[0];
				r.month       = date_b[1];
				r.day         = date_b[2];
				r.hour        = date_b[3];
				r.minute      = date_b[4];
			end
			pending_decodes.push_back(r);
		endfunction

		function void close_frame(input logic start_drop);
			mode        = MODE_HUNT;
			position    = '0;
			head_window = '0;
			tail_good   = 1'b1;
			dropping    = start_drop;
		endfunction

		// advance the deframer by one accepted byte
		function void take_byte(input logic [7:0] b, input logic ce);
			logic [4:0] pos;
			logic [4:0] tail_at;
			int k;
			bytes_taken++;
			if (dropping) begin
				if (ce)
					dropping = 1'b0;
				return;
			end
			// header hunt with a sliding window
			if (mode == MODE_HUNT) begin
				if (head_window == HEAD_PREFIX && b == HEAD_LAST) begin
					head_window = '0;
					mode        = MODE_POINT_HDR;
					position    = POS_AFTER_HEAD;
					tail_good   = 1'b1;
				end else begin
					head_window = {head_window[23:0], b};
				end
				return;
			end
			pos = position;
			if (pos == POS_MARK && b == TIME_MARK)
				mode = MODE_TIME_HDR;
			// type byte
			if (pos == POS_TYPE) begin
				if (mode == MODE_TIME_HDR) begin
					if (b == TYPE_REQUEST) begin
						mode = MODE_TIME_PLAIN;
						owe(KIND_TIME_REQ, 1'b0, 1'b0, 1'b0);
					end else if (b == TYPE_SET) begin
						mode = MODE_TIME_SET;
					end else begin
						mode = MODE_TIME_PLAIN;
					end
				end else if (b == TYPE_REQUEST) begin
					mode = MODE_REQ;
				end else if (b == TYPE_SET) begin
					mode = MODE_CMD;
				end else begin
					owe(KIND_BAD_TYPE, 1'b0, 1'b0, 1'b0);
					close_frame(!ce);
					return;
				end
			end
			// point payload
			if (mode == MODE_REQ || mode == MODE_CMD) begin
				if (pos == POS_GROUP)
					group_b = b;
				if (pos == POS_INDEX) begin
					index_b = b;
					if (mode == MODE_REQ)
						owe(KIND_POINT_REQ, 1'b1, 1'b0, 1'b0);
				end
				if (mode == MODE_CMD && pos >= POS_VALUE_LO && pos <= POS_VALUE_HI) begin
					value_acc = {value_acc[23:0], b};
					if (pos == POS_VALUE_HI)
						owe(KIND_POINT_CMD, 1'b1, 1'b1, 1'b0);
				end
			end
			// date payload
			if (mode == MODE_TIME_SET && pos >= POS_DATE_LO && pos <= POS_DATE_HI) begin
				date_b[3'(pos - POS_DATE_LO)] = b;
				if (pos == POS_DATE_HI)
					owe(KIND_TIME_SET, 1'b0, 1'b0, 1'b1);
			end
			// tail check, verdict on its last byte
			tail_at = (mode == MODE_REQ) ? POS_TAIL_REQ : POS_TAIL_STD;
			if (pos >= tail_at && pos <= tail_at + TAIL_LEN_M1) begin
				k = int'(pos - tail_at);
				if (b != TAIL_TEXT[39 - 8*k -: 8])
					tail_good = 1'b0;
				if (pos == tail_at + TAIL_LEN_M1) begin
					if (!tail_good) begin
						owe(KIND_BAD_TAIL, 1'b0, 1'b0, 1'b0);
						close_frame(!ce);
					end else begin
						close_frame(1'b0);
					end
					return;
				end
			end
			position = pos + 5'd1;
		endfunction

		function string describe(input pfd_result_t r);
			return $sformatf("kind %0d group %h index %h value %h date %h %h %h %h %h",
				r.kind, r.point_group, r.point_index, r.point_value,
				r.year_offset, r.month, r.day, r.hour, r.minute);
		endfunction

		function void note_fault(input string msg);
			if (decode_faults < REPORT_MAX)
				$display("decode mismatch at %0t: %s", $realtime, msg);
			decode_faults++;
		endfunction

		// compare one item leaving the block with the oldest decode owed
		function void match_decode(input pfd_result_t got);
			pfd_result_t want;
			if (pending_decodes.size() == 0) begin
				note_fault({"unexpected item, got ", describe(got)});
				return;
			end
			want = pending_decodes.pop_front();
			if (got !== want)
				note_fault({"expected ", describe(want), " got ", describe(got)});
			if (want.kind <= KIND_BAD_TAIL)
				kind_seen[want.kind]++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pfd_in_if  in_ch();
	pfd_out_if out_ch();

	point_frame_deframer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	point_frame_tracker tracker = new();
	link_byte_t burst[$];
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int hold_off_cycles = 0;
	int frame_bytes     = 0;
	int quiet_cycles    = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// accepted items on both sides, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				tracker.take_byte(in_ch.rx_byte, in_ch.chunk_end);
			if (out_ch.valid && out_ch.ready)
				tracker.match_decode({out_ch.kind, out_ch.point_group, out_ch.point_index,
					out_ch.point_value, out_ch.year_offset, out_ch.month, out_ch.day,
					out_ch.hour, out_ch.minute});
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no item moved for %0d cycles, %0d decodes outstanding",
					quiet_cycles, tracker.pending_decodes.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offer one byte, with random gaps before it, until it is taken
	task automatic send_byte(input logic [7:0] b, input logic ce);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.rx_byte   <= b;
		in_ch.chunk_end <= ce;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_burst();
		link_byte_t lb;
		while (burst.size() > 0) begin
			lb = burst.pop_front();
			send_byte(lb.data, lb.last);
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic ce);
		link_byte_t lb;
		lb.data = b;
		lb.last = ce;
		burst.push_back(lb);
	endtask

	task automatic push_noise(input int n, input int ce_pct);
		repeat (n) push_byte(8'($urandom), $urandom_range(99) < ce_pct);
	endtask

	function automatic logic [7:0] odd_type();
		logic [7:0] b;
		b = 8'($urandom);
		while (b == TYPE_REQUEST || b == TYPE_SET)
			b = 8'($urandom);
		return b;
	endfunction

	// one frame from header to tail; a bad type in a point frame ends it at the type byte
	task automatic push_frame(input logic time_frame, input logic [7:0] type_b,
		input logic [63:0] body, input int bad_tail_at, input logic [7:0] tail_flip,
		input int ce_pct);
		logic [7:0] b;
		int p;
		int tail_at;
		int last_pos;
		tail_at = 31;
		if (!time_frame && type_b != TYPE_REQUEST && type_b != TYPE_SET) begin
			last_pos = int'(POS_TYPE);
		end else begin
			tail_at  = (!time_frame && type_b == TYPE_REQUEST) ? int'(POS_TAIL_REQ)
				: int'(POS_TAIL_STD);
			last_pos = tail_at + int'(TAIL_LEN_M1);
		end
		for (p = 0; p < 4; p++)
			push_byte(HEAD_PREFIX[31 - 8*p -: 8], $urandom_range(99) < ce_pct);
		push_byte(HEAD_LAST, $urandom_range(99) < ce_pct);
		for (p = int'(POS_MARK); p <= last_pos; p++) begin
			if (p == POS_MARK) begin
				b = time_frame ? TIME_MARK : 8'($urandom);
				if (!time_frame && b == TIME_MARK)
					b = ~b;
			end else if (p == POS_TYPE) begin
				b = type_b;
			end else if (p >= tail_at) begin
				b = TAIL_TEXT[39 - 8*(p - tail_at) -: 8]
					^ ((p - tail_at == bad_tail_at) ? tail_flip : 8'h00);
			end else if (p >= POS_GROUP && p < 20) begin
				b = body[63 - 8*(p - POS_GROUP) -: 8];
			end else begin
				b = 8'($urandom);
			end
			push_byte(b, $urandom_range(99) < ce_pct);
			frame_bytes++;
		end
	endtask

	// mostly well-formed frames, some noise, broken tails and bad types
	task automatic push_random_frame();
		int pick;
		int flip_at;
		logic [7:0] flip;
		logic [63:0] body;
		logic broken;
		pick    = $urandom_range(99);
		flip_at = $urandom_range(4);
		flip    = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		body    = {$urandom, $urandom};
		broken  = (flip != 8'h00);
		if (pick < 10) begin
			if ($urandom_range(1) == 1) begin
				push_byte(HEAD_PREFIX[31:24], 1'b0);
				push_byte(HEAD_PREFIX[23:16], 1'b0);
				push_byte(HEAD_PREFIX[15:8], 1'b0);
			end
			push_noise($urandom_range(1, 8), 10);
			frame_bytes++;
			broken = 1'b0;
		end else if (pick < 35) begin
			push_frame(1'b0, TYPE_REQUEST, body, flip_at, flip, 4);
		end else if (pick < 60) begin
			push_frame(1'b0, TYPE_SET, body, flip_at, flip, 4);
		end else if (pick < 70) begin
			push_frame(1'b1, TYPE_REQUEST, body, flip_at, flip, 4);
		end else if (pick < 85) begin
			push_frame(1'b1, TYPE_SET, body, flip_at, flip, 4);
		end else if (pick < 90) begin
			push_frame(1'b1, odd_type(), body, flip_at, flip, 4);
		end else begin
			push_frame(1'b0, odd_type(), body, 0, 8'h00, 4);
			broken = 1'b1;
		end
		// mostly close the chunk after an error, sometimes let the drop eat on
		if (broken && $urandom_range(4) != 0) begin
			push_noise($urandom_range(0, 4), 0);
			push_byte(8'($urandom), 1'b1);
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int hold);
		int goal;
		send_idle_pct   = idle_pct;
		recv_stall_pct  = stall_pct;
		hold_off_cycles = hold;
		goal = frame_bytes + PHASE_BYTES;
		while (frame_bytes < goal) begin
			push_random_frame();
			send_burst();
		end
	endtask

	initial begin
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.rx_byte   <= 8'h00;
		in_ch.chunk_end <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial header right before a real one, then point request extremes
		push_byte(HEAD_PREFIX[31:24], 1'b0);
		push_byte(HEAD_PREFIX[23:16], 1'b0);
		push_byte(HEAD_PREFIX[15:8], 1'b0);
		push_byte(HEAD_PREFIX[7:0], 1'b0);
		push_frame(1'b0, TYPE_REQUEST, {8'h00, 8'hFF, 48'h0}, 0, 8'h00, 0);
		// point commands with extreme values
		push_frame(1'b0, TYPE_SET, {8'hFF, 8'h00, 32'h8000_0001, 16'h0}, 0, 8'h00, 0);
		push_frame(1'b0, TYPE_SET, {8'h7E, 8'h81, 32'hFFFF_FFFF, 16'hFFFF}, 0, 8'h00, 0);
		push_frame(1'b0, TYPE_SET, {8'h00, 8'h00, 32'h0000_0000, 16'h0}, 0, 8'h00, 0);
		// time request and time sets
		push_frame(1'b1, TYPE_REQUEST, 64'hFFFF_FFFF_FFFF_FFFF, 0, 8'h00, 0);
		push_frame(1'b1, TYPE_SET, {40'hFF_FF_FF_FF_FF, 24'h0}, 0, 8'h00, 0);
		push_frame(1'b1, TYPE_SET, {40'h00_01_1F_17_3B, 24'hFFFFFF}, 0, 8'h00, 0);
		// time frame with an unknown type: silent, good then bad tail
		push_frame(1'b1, 8'h7F, 64'h0, 0, 8'h00, 0);
		push_frame(1'b1, 8'h80, 64'h0, 2, 8'h01, 0);
		push_noise(3, 0);
		push_byte(8'h00, 1'b1);
		// bad type carrying chunk end itself, next frame right behind it
		push_frame(1'b0, 8'h41, 64'h0, 0, 8'h00, 0);
		burst[burst.size() - 1].last = 1'b1;
		push_frame(1'b0, TYPE_REQUEST, {8'h12, 8'h34, 48'h0}, 0, 8'h00, 0);
		// bad type: a whole frame is dropped until the chunk ends
		push_frame(1'b0, 8'hFF, 64'h0, 0, 8'h00, 0);
		push_frame(1'b0, TYPE_REQUEST, {8'h56, 8'h78, 48'h0}, 0, 8'h00, 0);
		burst[burst.size() - 1].last = 1'b1;
		// bad tail with chunk end on its last byte: nothing to drop
		push_frame(1'b0, TYPE_REQUEST, {8'h9A, 8'hBC, 48'h0}, 4, 8'h80, 0);
		burst[burst.size() - 1].last = 1'b1;
		// bad tail on a command's first tail byte, drop up to the chunk end
		push_frame(1'b0, TYPE_SET, {8'hDE, 8'hAD, 32'h3F80_0000, 16'h0}, 0, 8'hFF, 0);
		push_frame(1'b0, TYPE_REQUEST, {8'h01, 8'h02, 48'h0}, 0, 8'h00, 0);
		burst[burst.size() - 1].last = 1'b1;
		// chunk ends inside frames are ignored
		push_frame(1'b0, TYPE_SET, {8'hA5, 8'h5A, 32'h1234_5678, 16'h0}, 0, 8'h00, 40);
		push_frame(1'b1, TYPE_SET, {40'h18_0C_0A_00_00, 24'h0}, 0, 8'h00, 40);
		send_burst();

		// random frames under each idling pattern, first with a long output hold-off
		run_phase(0, 0, HOLD_CYCLES);
		run_phase(70, 0, 0);
		run_phase(0, 70, 0);
		run_phase(12, 12, 0);
		in_ch.valid <= 1'b0;

		// let the last decodes come out, then watch for strays
		while (tracker.pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d link bytes in four idling patterns, %0d-cycle output hold-off",
			tracker.bytes_taken, HOLD_CYCLES);
		$display("decodes: %0d pt req, %0d pt cmd, %0d tm req, %0d tm set, %0d type, %0d tail",
			tracker.kind_seen[KIND_POINT_REQ], tracker.kind_seen[KIND_POINT_CMD],
			tracker.kind_seen[KIND_TIME_REQ], tracker.kind_seen[KIND_TIME_SET],
			tracker.kind_seen[KIND_BAD_TYPE], tracker.kind_seen[KIND_BAD_TAIL]);
		if (tracker.decode_faults == 0 && tracker.pending_decodes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d decodes never seen", tracker.decode_faults,
				tracker.pending_decodes.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
